// ----- src/nbbc_pkg.sv -----
// Shared constants for the naive Bayes classifier: score format and log2 unit sizes.
package nbbc_pkg;

    // Score format: signed, 16 fractional bits
    localparam int SCORE_W   = 26;
    localparam int FRAC_BITS = 16;

    // log2 mantissa, 1.31 fixed point
    localparam int MANT_W = 32;

    // log2(1e-7) in Q.16, rounded to nearest
    localparam int LOG2_FLOOR = -1523941;

    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

endpackage

// ----- src/nbbc_log2.sv -----
// Iterative log2 unit: bit-serial normalize, then one squaring per fraction bit.
module nbbc_log2 #(
    parameter int XW = 17,
    localparam int NW = (XW > nbbc_pkg::MANT_W) ? XW : nbbc_pkg::MANT_W,
    localparam int LW = $clog2(NW) + nbbc_pkg::FRAC_BITS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [XW-1:0] x,
    output logic          busy,
    output logic          done,
    output logic [LW-1:0] result
);
    import nbbc_pkg::*;

    localparam int EW = $clog2(NW);
    localparam int IW = $clog2(FRAC_BITS);

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_NORM = 2'd1;
    localparam logic [1:0] L_MUL  = 2'd2;
    localparam logic [1:0] L_SQ   = 2'd3;

    logic [1:0]            st_reg,   st_next;
    logic                  done_reg, done_next;
    logic [NW-1:0]         norm_reg, norm_next;
    logic [EW-1:0]         exp_reg,  exp_next;
    logic [MANT_W-1:0]     mant_reg, mant_next;
    logic [2*MANT_W-1:0]   prod_reg, prod_next;
    logic [FRAC_BITS-1:0]  frac_reg, frac_next;
    logic [IW-1:0]         it_reg,   it_next;
    logic [MANT_W:0]       sq;

    // square >> 31, back in 1.31 (with one extra integer bit)
    assign sq = prod_reg[2*MANT_W-1:MANT_W-1];

    always_comb begin
        st_next   = st_reg;
        done_next = 1'b0;
        norm_next = norm_reg;
        exp_next  = exp_reg;
        mant_next = mant_reg;
        prod_next = prod_reg;
        frac_next = frac_reg;
        it_next   = it_reg;
        unique case (st_reg)
            L_IDLE: begin
                if (start) begin
                    norm_next = NW'(x);
                    exp_next  = EW'(NW - 1);
                    frac_next = '0;
                    st_next   = L_NORM;
                end
            end
            L_NORM: begin
                if (norm_reg[NW-1] || exp_reg == '0) begin
                    mant_next = norm_reg[NW-1 -: MANT_W];
                    it_next   = IW'(FRAC_BITS - 1);
                    st_next   = L_MUL;
                end else begin
                    norm_next = norm_reg << 1;
                    exp_next  = exp_reg - 1'b1;
                end
            end
            L_MUL: begin
                prod_next = mant_reg * mant_reg;
                st_next   = L_SQ;
            end
            L_SQ: begin
                if (sq[MANT_W]) begin
                    mant_next = sq[MANT_W:1];
                    frac_next = {frac_reg[FRAC_BITS-2:0], 1'b1};
                end else begin
                    mant_next = sq[MANT_W-1:0];
                    frac_next = {frac_reg[FRAC_BITS-2:0], 1'b0};
                end
                if (it_reg == '0) begin
                    done_next = 1'b1;
                    st_next   = L_IDLE;
                end else begin
                    it_next = it_reg - 1'b1;
                    st_next = L_MUL;
                end
            end
            default: st_next = L_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= L_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        norm_reg <= norm_next;
        exp_reg  <= exp_next;
        mant_reg <= mant_next;
        prod_reg <= prod_next;
        frac_reg <= frac_next;
        it_reg   <= it_next;
    end

    assign busy   = (st_reg != L_IDLE);
    assign done   = done_reg;
    assign result = {exp_reg, frac_reg};

endmodule

// ----- src/naive_bayes_binary_classifier_unit.sv -----
// Two-class categorical naive Bayes classifier, one feature value per item, log2 scores.
// Flow: a counted training item reads its count and writes it back plus one; any other
//   training item goes straight to the end step. A classify item takes log2(count) and
//   log2(class count) for each class, each run normalizing over NW = max(32, COUNT_WIDTH+1)
//   bits; a floor term skips both runs. A classify item ending a sample adds prior work
//   before the result. One item at a time; the shared log2 unit's squaring loop sets the
//   rate. Results wait in an output register.
// Reset: synchronous, active low; then a clearing pass over all 2*NUM_FEATURES*NUM_VALUES
//   table entries (512 at defaults) zeroes the count table before the first item is taken.
module naive_bayes_binary_classifier_unit #(
    parameter int NUM_FEATURES = 16,
    parameter int NUM_VALUES   = 16,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [0] label, [8:1] feature_value, [15:9] zero
    input  logic        s_tuser,   // [0] command
    input  logic        s_tlast,   // last feature of the sample
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [0] predicted_class, [26:1] score_negative,
                                   // [52:27] score_positive, [55:53] zero
    output logic        m_tuser    // [0] status
);
    import nbbc_pkg::*;

    // Sizes
    localparam int XW         = COUNT_WIDTH + 1;           // total sample count width
    localparam int NW         = (XW > MANT_W) ? XW : MANT_W;
    localparam int LW         = $clog2(NW) + FRAC_BITS;    // log2 result width
    localparam int TW         = LW + 1;                    // signed term width
    localparam int SUMW       = SCORE_W + 1;
    localparam int TABLE_SIZE = 2 * NUM_FEATURES * NUM_VALUES;
    localparam int AW         = $clog2(TABLE_SIZE);
    localparam int PW         = $clog2(NUM_FEATURES + 1);

    localparam logic CMD_TRAIN    = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;
    localparam logic CLS_NEG      = 1'b0;
    localparam logic CLS_POS      = 1'b1;

    // Sequencer states
    localparam logic [3:0] S_CLEAR   = 4'd0;   // zeroing the count table
    localparam logic [3:0] S_IDLE    = 4'd1;   // ready for an item
    localparam logic [3:0] S_TRN_RD  = 4'd2;   // read count
    localparam logic [3:0] S_TRN_WR  = 4'd3;   // write saturated count + 1
    localparam logic [3:0] S_CLS_RD  = 4'd4;   // read count for class cls
    localparam logic [3:0] S_CLS_CHK = 4'd5;   // count back: floor term or log2(count)
    localparam logic [3:0] S_LOG_A   = 4'd6;   // wait log2(count), start log2(class count)
    localparam logic [3:0] S_LOG_B   = 4'd7;   // wait log2(class count)
    localparam logic [3:0] S_CLS_ADD = 4'd8;   // add term to running score
    localparam logic [3:0] S_END     = 4'd9;   // position, end of sample
    localparam logic [3:0] S_FIN     = 4'd10;  // prior for class cls
    localparam logic [3:0] S_PRI_A   = 4'd11;  // wait log2(class count), start log2(total)
    localparam logic [3:0] S_PRI_B   = 4'd12;  // wait log2(total)
    localparam logic [3:0] S_PRI_ADD = 4'd13;  // final score of class cls
    localparam logic [3:0] S_EMIT    = 4'd14;  // hand result to the output register

    // Control state
    logic [3:0]                    state_reg, state_next;
    logic [AW-1:0]                 clr_reg,   clr_next;
    logic [COUNT_WIDTH-1:0]        cs_reg    [2];
    logic [COUNT_WIDTH-1:0]        cs_next   [2];
    logic [XW-1:0]                 total_reg, total_next;
    logic [PW-1:0]                 pos_reg,   pos_next;
    logic signed [SCORE_W-1:0]     score_reg [2];
    logic signed [SCORE_W-1:0]     score_next[2];
    logic                          cls_reg,   cls_next;
    logic                          mv_reg,    mv_next;

    // Item and working payload
    logic                          cmd_reg,   cmd_next;
    logic                          lbl_reg,   lbl_next;
    logic [7:0]                    val_reg,   val_next;
    logic                          last_reg,  last_next;
    logic                          inr_reg,   inr_next;   // position inside the table
    logic                          vin_reg,   vin_next;   // value inside the table
    logic signed [TW-1:0]          term_reg,  term_next;
    logic signed [SCORE_W-1:0]     fin_reg   [2];
    logic signed [SCORE_W-1:0]     fin_next  [2];
    logic                          stat_reg,  stat_next;

    // Output register payload
    logic                          oc_reg,    oc_next;
    logic signed [SCORE_W-1:0]     on_reg,    on_next;
    logic signed [SCORE_W-1:0]     op_reg,    op_next;
    logic                          os_reg,    os_next;

    // Count table
    logic [COUNT_WIDTH-1:0]        mem [TABLE_SIZE];
    logic [COUNT_WIDTH-1:0]        rd_reg;
    logic [AW-1:0]                 mem_addr;
    logic                          mem_we;
    logic [COUNT_WIDTH-1:0]        mem_wdata;
    logic                          tbl_cls;

    // Shared log2 unit
    logic                          log_start;
    logic [XW-1:0]                 log_x;
    logic                          log_busy;
    logic                          log_done;
    logic [LW-1:0]                 log_res;

    // Saturating score add
    function automatic logic signed [SCORE_W-1:0] sat_add(
        input logic signed [SCORE_W-1:0] a,
        input logic signed [TW-1:0]      b
    );
        logic signed [SUMW-1:0] s;
        s = SUMW'(a) + SUMW'(b);
        if (s[SUMW-1] != s[SUMW-2]) begin
            return s[SUMW-1] ? SCORE_MIN : SCORE_MAX;
        end
        return s[SCORE_W-1:0];
    endfunction

    nbbc_log2 #(
        .XW(XW)
    ) u_log2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (log_start),
        .x       (log_x),
        .busy    (log_busy),
        .done    (log_done),
        .result  (log_res)
    );

    // Table address: class, feature position, value
    assign tbl_cls  = (state_reg == S_TRN_RD || state_reg == S_TRN_WR) ? lbl_reg : cls_reg;
    assign mem_addr = (state_reg == S_CLEAR) ? clr_reg :
                      AW'((32'(tbl_cls) * NUM_FEATURES + 32'(pos_reg)) * NUM_VALUES
                          + 32'(val_reg));

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_reg <= mem[mem_addr];
    end

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cs_next    = cs_reg;
        total_next = total_reg;
        pos_next   = pos_reg;
        score_next = score_reg;
        cls_next   = cls_reg;
        mv_next    = mv_reg && !m_tready;
        cmd_next   = cmd_reg;
        lbl_next   = lbl_reg;
        val_next   = val_reg;
        last_next  = last_reg;
        inr_next   = inr_reg;
        vin_next   = vin_reg;
        term_next  = term_reg;
        fin_next   = fin_reg;
        stat_next  = stat_reg;
        oc_next    = oc_reg;
        on_next    = on_reg;
        op_next    = op_reg;
        os_next    = os_reg;
        mem_we     = 1'b0;
        mem_wdata  = '0;
        log_start  = 1'b0;
        log_x      = '0;

        unique case (state_reg)
            S_CLEAR: begin
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(TABLE_SIZE - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next  = s_tuser;
                    lbl_next  = s_tdata[0];
                    val_next  = s_tdata[8:1];
                    last_next = s_tlast;
                    inr_next  = (32'(pos_reg) < NUM_FEATURES);
                    vin_next  = (32'(s_tdata[8:1]) < NUM_VALUES);
                    if (inr_next && s_tuser == CMD_TRAIN && vin_next) begin
                        state_next = S_TRN_RD;
                    end else if (inr_next && s_tuser == CMD_CLASSIFY) begin
                        cls_next   = CLS_NEG;
                        state_next = S_CLS_RD;
                    end else begin
                        state_next = S_END;
                    end
                end
            end
            S_TRN_RD: begin
                state_next = S_TRN_WR;
            end
            S_TRN_WR: begin
                mem_we     = 1'b1;
                mem_wdata  = (&rd_reg) ? rd_reg : rd_reg + 1'b1;
                state_next = S_END;
            end
            S_CLS_RD: begin
                if (vin_reg && cs_reg[cls_reg] != '0) begin
                    state_next = S_CLS_CHK;
                end else begin
                    term_next  = TW'(LOG2_FLOOR);
                    state_next = S_CLS_ADD;
                end
            end
            S_CLS_CHK: begin
                if (rd_reg == '0) begin
                    term_next  = TW'(LOG2_FLOOR);
                    state_next = S_CLS_ADD;
                end else begin
                    log_start  = 1'b1;
                    log_x      = XW'(rd_reg);
                    state_next = S_LOG_A;
                end
            end
            S_LOG_A: begin
                if (log_done) begin
                    term_next  = $signed({1'b0, log_res});
                    log_start  = 1'b1;
                    log_x      = XW'(cs_reg[cls_reg]);
                    state_next = S_LOG_B;
                end
            end
            S_LOG_B: begin
                if (log_done) begin
                    term_next  = term_reg - $signed({1'b0, log_res});
                    state_next = S_CLS_ADD;
                end
            end
            S_CLS_ADD: begin
                score_next[cls_reg] = sat_add(score_reg[cls_reg], term_reg);
                if (cls_reg == CLS_NEG) begin
                    cls_next   = CLS_POS;
                    state_next = S_CLS_RD;
                end else begin
                    state_next = S_END;
                end
            end
            S_END: begin
                if (inr_reg) begin
                    pos_next = pos_reg + 1'b1;
                end
                state_next = S_IDLE;
                if (last_reg) begin
                    pos_next = '0;
                    if (cmd_reg == CMD_TRAIN) begin
                        // class count and total move together, so total never saturates
                        if (cs_reg[lbl_reg] != '1) begin
                            cs_next[lbl_reg] = cs_reg[lbl_reg] + 1'b1;
                            total_next       = total_reg + 1'b1;
                        end
                        score_next[0] = '0;
                        score_next[1] = '0;
                    end else begin
                        cls_next   = CLS_NEG;
                        stat_next  = 1'b0;
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (cs_reg[cls_reg] == '0) begin
                    // empty class: lowest score, flagged
                    fin_next[cls_reg] = SCORE_MIN;
                    stat_next         = 1'b1;
                    if (cls_reg == CLS_NEG) begin
                        cls_next = CLS_POS;
                    end else begin
                        state_next = S_EMIT;
                    end
                end else begin
                    log_start  = 1'b1;
                    log_x      = XW'(cs_reg[cls_reg]);
                    state_next = S_PRI_A;
                end
            end
            S_PRI_A: begin
                if (log_done) begin
                    term_next  = $signed({1'b0, log_res});
                    log_start  = 1'b1;
                    log_x      = total_reg;
                    state_next = S_PRI_B;
                end
            end
            S_PRI_B: begin
                if (log_done) begin
                    term_next  = term_reg - $signed({1'b0, log_res});
                    state_next = S_PRI_ADD;
                end
            end
            S_PRI_ADD: begin
                fin_next[cls_reg] = sat_add(score_reg[cls_reg], term_reg);
                if (cls_reg == CLS_NEG) begin
                    cls_next   = CLS_POS;
                    state_next = S_FIN;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!mv_reg || m_tready) begin
                    mv_next       = 1'b1;
                    oc_next       = (fin_reg[0] > fin_reg[1]) ? CLS_NEG : CLS_POS;
                    on_next       = fin_reg[0];
                    op_next       = fin_reg[1];
                    os_next       = stat_reg;
                    score_next[0] = '0;
                    score_next[1] = '0;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            cs_reg[0]    <= '0;
            cs_reg[1]    <= '0;
            total_reg    <= '0;
            pos_reg      <= '0;
            score_reg[0] <= '0;
            score_reg[1] <= '0;
            cls_reg      <= CLS_NEG;
            mv_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            cs_reg       <= cs_next;
            total_reg    <= total_next;
            pos_reg      <= pos_next;
            score_reg    <= score_next;
            cls_reg      <= cls_next;
            mv_reg       <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        lbl_reg  <= lbl_next;
        val_reg  <= val_next;
        last_reg <= last_next;
        inr_reg  <= inr_next;
        vin_reg  <= vin_next;
        term_reg <= term_next;
        fin_reg  <= fin_next;
        stat_reg <= stat_next;
        oc_reg   <= oc_next;
        on_reg   <= on_next;
        op_reg   <= op_next;
        os_reg   <= os_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = {3'b000, op_reg, on_reg, oc_reg};
    assign m_tuser  = os_reg;

    // The position never exceeds NUM_FEATURES
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(pos_reg) <= NUM_FEATURES)
        else $error("feature position beyond NUM_FEATURES");

    // Total count tracks the two class counts
    a_total_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg == XW'(cs_reg[0]) + XW'(cs_reg[1]))
        else $error("total sample count out of step with class counts");

    // The log2 unit is only started when free
    a_log_free: assert property (@(posedge aclk) disable iff (!aresetn)
        log_start |-> !log_busy)
        else $error("log2 unit started while busy");

    // One item at a time: after an accept the block is busy
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while one is in work");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the two-class categorical naive Bayes classifier unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nbbc_pkg::*;

    localparam int NF = 16;             // feature positions per sample
    localparam int NV = 16;             // categorical values per position
    localparam int CW = 16;             // count width
    localparam int IDLE_LIMIT = 10000;  // cycles without any handshake before giving up
    localparam int HOLD_CYCLES = 1500;  // long receiver hold-off

    localparam bit CMD_TRAIN    = 1'b0;
    localparam bit CMD_CLASSIFY = 1'b1;
    localparam bit CLASS_NEG    = 1'b0;
    localparam bit CLASS_POS    = 1'b1;

    localparam longint SAT_LO = longint'(SCORE_MIN);
    localparam longint SAT_HI = longint'(SCORE_MAX);

    typedef struct {
        bit                         cls;
        logic signed [SCORE_W-1:0]  neg;
        logic signed [SCORE_W-1:0]  pos;
        bit                         stat;
    } verdict_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tuser;

    naive_bayes_binary_classifier_unit #(
        .NUM_FEATURES(NF),
        .NUM_VALUES  (NV),
        .COUNT_WIDTH (CW)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // ---------------------------------------------------------------
    // Classifier state as predicted by the testbench
    // ---------------------------------------------------------------
    logic [CW-1:0] tally [2][NF][NV];   // (class, position, value) counts
    logic [CW-1:0] class_total [2];     // training samples per class
    logic [CW:0]   sample_total;        // sum of both class counts
    int unsigned   feat_pos;            // position of the next item in the sample
    longint        run_score [2];       // running log2 score per class

    verdict_t verdict_q[$];             // expected results, oldest first

    int  mismatch_count = 0;
    int  result_count   = 0;
    int  items_sent     = 0;
    bit  gaps_on        = 1'b1;         // random idling on both sides
    int  hold_req       = 0;            // receiver hold-off request, in cycles
    verdict_t got;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // log2 of x >= 1 in Q.16: integer part from the leading one, then 16
    // fraction bits by repeated squaring of a 1.31 mantissa
    function automatic longint log2_fix(input longint unsigned x);
        int              n;
        int              b;
        longint unsigned m;
        longint          r;
        if (x == 0)
            return 0;
        n = 63;
        while (n > 0 && x[n] == 1'b0)
            n--;
        if (n >= 31)
            m = x >> (n - 31);
        else
            m = x << (31 - n);
        r = longint'(n) * 65536;
        for (b = 15; b >= 0; b--) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                r += longint'(1) << b;
            end
        end
        return r;
    endfunction

    function automatic longint clamp_score(input longint v);
        if (v < SAT_LO)
            return SAT_LO;
        if (v > SAT_HI)
            return SAT_HI;
        return v;
    endfunction

    // Update the predicted state with one accepted item; queue a verdict when
    // a classify sample ends.
    task automatic classify_and_count(input bit cmd, input bit lab, input logic [7:0] val,
                                      input bit lst);
        longint   term;
        longint   fin [2];
        verdict_t v;
        v.stat = 1'b0;
        if (feat_pos < NF) begin
            if (cmd == CMD_TRAIN) begin
                if (val < NV) begin
                    if (tally[lab][feat_pos][val] != {CW{1'b1}})
                        tally[lab][feat_pos][val]++;
                end
            end else begin
                for (int c = 0; c < 2; c++) begin
                    term = longint'(LOG2_FLOOR);
                    if (val < NV && class_total[c] != 0) begin
                        if (tally[c][feat_pos][val] != 0)
                            term = log2_fix(tally[c][feat_pos][val]) - log2_fix(class_total[c]);
                    end
                    run_score[c] = clamp_score(run_score[c] + term);
                end
            end
            feat_pos++;
        end
        if (!lst)
            return;
        feat_pos = 0;
        if (cmd == CMD_TRAIN) begin
            // class count saturates; the total only follows a real bump
            if (class_total[lab] != {CW{1'b1}}) begin
                class_total[lab]++;
                sample_total++;
            end
        end else begin
            for (int c = 0; c < 2; c++) begin
                if (class_total[c] == 0) begin
                    fin[c] = SAT_LO;
                    v.stat = 1'b1;
                end else begin
                    fin[c] = clamp_score(run_score[c] + log2_fix(class_total[c])
                                         - log2_fix(sample_total));
                end
            end
            v.cls = (fin[0] > fin[1]) ? CLASS_NEG : CLASS_POS;   // tie goes to class 1
            v.neg = fin[0][SCORE_W-1:0];
            v.pos = fin[1][SCORE_W-1:0];
            verdict_q.insert(verdict_q.size(), v);
        end
        run_score[0] = 0;
        run_score[1] = 0;
    endtask

    // Idle length: mostly short, sometimes medium, rarely long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic flag_error(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] ERROR: %s", $realtime, what);
    endtask

    // Offer one item and wait for the handshake. Always entered right after a
    // rising edge; drives only with nonblocking assignments.
    task automatic send_item(input bit cmd, input bit lab, input logic [7:0] val,
                             input bit lst);
        int gap;
        gap = (gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, val, lab};
        s_tuser  <= cmd;
        s_tlast  <= lst;
        do
            @(posedge aclk);
        while (!s_tready);
        classify_and_count(cmd, lab, val, lst);
        items_sent++;
    endtask

    // ---------------------------------------------------------------
    // Receiver: random idling, plus the long hold-off on request
    // ---------------------------------------------------------------
    initial begin : ready_driver
        int idle_left;
        int hold_left;
        idle_left = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                m_tready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                idle_left = pick_gap() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result checker: every accepted result against the oldest verdict
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (verdict_q.size() == 0) begin
                flag_error($sformatf("result %0d arrived with none expected: tdata=%h tuser=%b",
                                     result_count, m_tdata, m_tuser));
            end else begin
                got = verdict_q.pop_front();
                if (m_tdata[0] !== got.cls || m_tdata[26:1] !== got.neg
                        || m_tdata[52:27] !== got.pos || m_tuser !== got.stat
                        || m_tdata[55:53] !== 3'b0)
                    flag_error($sformatf({"result %0d expected/actual: class %0d/%0d ",
                                          "neg %0d/%0d pos %0d/%0d status %0d/%0d"},
                                         result_count, got.cls, m_tdata[0],
                                         got.neg, $signed(m_tdata[26:1]),
                                         got.pos, $signed(m_tdata[52:27]),
                                         got.stat, m_tuser));
            end
        end
    end

    // Watchdog: too long without any item moving on either side
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("Mismatches found");
        $finish;
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Classify with no training at all, then with only class 0 trained;
    // also a tie between two equally trained classes.
    task automatic test_empty_classes();
        send_item(CMD_CLASSIFY, CLASS_NEG, 8'd0, 1'b0);
        send_item(CMD_CLASSIFY, CLASS_POS, 8'd255, 1'b1);   // both empty
        send_item(CMD_TRAIN, CLASS_NEG, 8'd0, 1'b1);
        send_item(CMD_CLASSIFY, CLASS_NEG, 8'd0, 1'b1);     // class 1 empty
        send_item(CMD_TRAIN, CLASS_POS, 8'd0, 1'b1);
        send_item(CMD_CLASSIFY, CLASS_POS, 8'd0, 1'b1);     // identical classes: tie
    endtask

    // Values at the top end of the table and past it, label both ways
    task automatic test_table_edges();
        send_item(CMD_TRAIN, CLASS_POS, 8'(NV - 1), 1'b1);
        send_item(CMD_TRAIN, CLASS_NEG, 8'(NV - 1), 1'b0);
        send_item(CMD_TRAIN, CLASS_NEG, 8'(NV), 1'b1);      // not counted
        send_item(CMD_CLASSIFY, CLASS_NEG, 8'(NV - 1), 1'b0);
        send_item(CMD_CLASSIFY, CLASS_NEG, 8'(NV), 1'b1);   // floor term
        send_item(CMD_CLASSIFY, CLASS_POS, 8'd170, 1'b0);
        send_item(CMD_CLASSIFY, CLASS_POS, 8'd85, 1'b1);
    endtask

    // The last item's command decides how a mixed sample ends
    task automatic test_mixed_commands();
        send_item(CMD_TRAIN, CLASS_POS, 8'd3, 1'b0);
        send_item(CMD_TRAIN, CLASS_POS, 8'd255, 1'b0);
        send_item(CMD_CLASSIFY, CLASS_NEG, 8'd3, 1'b1);     // ends as classify
        send_item(CMD_CLASSIFY, CLASS_NEG, 8'd1, 1'b0);
        send_item(CMD_CLASSIFY, CLASS_POS, 8'd2, 1'b0);
        send_item(CMD_TRAIN, CLASS_NEG, 8'd2, 1'b1);        // ends as training
    endtask

    // Random samples: mostly full length with label-shaped content, some
    // short, some too long, a few with mixed commands
    task automatic test_random_samples(input int n_items);
        int         n0;
        int         len;
        int         kind;
        bit         sample_cmd;
        bit         mixed;
        bit         lab;
        bit         cmd;
        logic [7:0] val;
        n0 = items_sent;
        while (items_sent - n0 < n_items) begin
            gaps_on    = ($urandom_range(0, 3) != 0);
            kind       = $urandom_range(0, 99);
            len        = (kind < 50) ? NF :
                         (kind < 85) ? $urandom_range(1, NF - 1) : $urandom_range(NF + 1, NF + 6);
            sample_cmd = 1'($urandom_range(0, 1));
            mixed      = ($urandom_range(0, 19) == 0);
            lab        = 1'($urandom_range(0, 1));
            for (int p = 0; p < len; p++) begin
                cmd  = mixed ? 1'($urandom_range(0, 1)) : sample_cmd;
                kind = $urandom_range(0, 99);
                if (kind < 50)
                    val = 8'((lab ? p : NV - 1 - p) % NV);
                else if (kind < 90)
                    val = 8'($urandom_range(0, NV - 1));
                else
                    val = 8'($urandom_range(0, 255));
                send_item(cmd, lab, val, p == len - 1);
            end
        end
        gaps_on = 1'b1;
    endtask

    // Receiver holds off for a long stretch while short classify samples keep
    // coming, so the result register fills and the input stalls
    task automatic test_backpressure();
        int len;
        hold_req = HOLD_CYCLES;
        gaps_on  = 1'b0;
        repeat (12) begin
            len = $urandom_range(1, 3);
            for (int p = 0; p < len; p++)
                send_item(CMD_CLASSIFY, CLASS_NEG, 8'($urandom_range(0, NV - 1)), p == len - 1);
        end
        gaps_on = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        foreach (tally[c, f, v])
            tally[c][f][v] = '0;
        class_total[0] = '0;
        class_total[1] = '0;
        sample_total   = '0;
        feat_pos       = 0;
        run_score[0]   = 0;
        run_score[1]   = 0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // block clears its count table first; send_item waits on s_tready
        test_empty_classes();
        test_table_edges();
        test_mixed_commands();
        test_random_samples(350);
        test_backpressure();
        test_random_samples(350);
        s_tvalid <= 1'b0;

        while (verdict_q.size() != 0)
            @(posedge aclk);
        // a trailing training item may still be in flight; nothing more may appear
        repeat (600) @(posedge aclk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
